FILE: hdl/ome_pkg.sv
// ----------------------------------------------------------------------------
// ome_pkg
// Types, constants and the term program for the outer/middle ear filter chain.
// ----------------------------------------------------------------------------
package ome_pkg;

  localparam int SAMPLE_BITS  = 24;
  localparam int SIGNAL_BITS  = 48;
  localparam int OUT_BITS     = 48;
  localparam int COEF_BITS    = 33;
  localparam int HALF_BITS    = SIGNAL_BITS / 2;
  localparam int PART_BITS    = HALF_BITS + 1;
  localparam int PROD_BITS    = COEF_BITS + PART_BITS;
  localparam int ACC_BITS     = SIGNAL_BITS + 40;
  localparam int CFG_BITS     = 32;
  localparam int CFG_IDX_BITS = 3;
  localparam int SAMPLE_SHIFT = 16;
  localparam int Q30_SHIFT    = 30;
  localparam int AR_SHIFT     = 8;
  localparam int TERM_BITS    = 5;
  localparam int LAST_TERM    = 20;

  localparam logic signed [COEF_BITS-1:0] ONE_Q30  = 33'sd1073741824;
  localparam logic signed [COEF_BITS-1:0] GAIN_Q30 = 33'sd1909412977;
  localparam logic signed [COEF_BITS-1:0] HP_B0    = 33'sd932450869;
  localparam logic signed [COEF_BITS-1:0] HP_B1    = -33'sd1864901738;
  localparam logic signed [COEF_BITS-1:0] HP_NA1   = 33'sd1846228435;
  localparam logic signed [COEF_BITS-1:0] HP_NA2   = -33'sd809833218;

  localparam logic signed [ACC_BITS-1:0] Q30_HALF = ACC_BITS'(1) <<< (Q30_SHIFT - 1);
  localparam logic signed [ACC_BITS-1:0] AR_HALF  = ACC_BITS'(1) <<< (AR_SHIFT - 1);

  localparam logic signed [SIGNAL_BITS-1:0] SIG_MAX = {1'b0, {(SIGNAL_BITS-1){1'b1}}};
  localparam logic signed [SIGNAL_BITS-1:0] SIG_MIN = {1'b1, {(SIGNAL_BITS-1){1'b0}}};

  localparam logic signed [31:0] RST_CONCHA_B0 = 32'sd104024000;
  localparam logic signed [31:0] RST_CONCHA_A1 = -32'sd1851177000;
  localparam logic signed [31:0] RST_CONCHA_A2 = 32'sd865710000;
  localparam logic signed [31:0] RST_CANAL_B0  = 32'sd57951000;
  localparam logic signed [31:0] RST_CANAL_A1  = -32'sd1800800000;
  localparam logic signed [31:0] RST_CANAL_A2  = 32'sd957862000;
  localparam logic [23:0]        RST_AR_SCALE  = 24'd549756;
  localparam logic [30:0]        RST_LP_ALPHA  = 31'd1529870;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_CONCHA_B0, CFG_CONCHA_A1, CFG_CONCHA_A2,
    CFG_CANAL_B0,  CFG_CANAL_A1,  CFG_CANAL_A2,
    CFG_AR_SCALE,  CFG_LP_ALPHA
  } cfg_idx_t;

  typedef enum logic [2:0] {
    STG_NX, STG_CONCHA, STG_ECIN, STG_CANAL, STG_ECOUT, STG_AR, STG_HP, STG_LP
  } stage_t;

  typedef enum logic [4:0] {
    C_NEG_ONE, C_ONE, C_GAIN, C_CB0, C_NCB0, C_NCA1, C_NCA2,
    C_KB0, C_NKB0, C_NKA1, C_NKA2, C_AR, C_HPB0, C_HPB1,
    C_HPNA1, C_HPNA2, C_ALPHA, C_ONE_M_ALPHA
  } coef_sel_t;

  typedef enum logic [3:0] {
    X_SAMPLE, X_WORK, X_CIN1, X_COUT0, X_COUT1, X_KIN0, X_KIN1,
    X_KOUT0, X_KOUT1, X_SIN0, X_SIN1, X_VEL0, X_VEL1, X_DISP
  } opnd_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LO, ST_HI, ST_DRAIN, ST_FINISH, ST_OUT
  } state_t;

  typedef struct packed {
    coef_sel_t coef;
    opnd_sel_t opnd;
    logic      last;
  } term_t;

  typedef struct packed {
    logic      load_in;
    logic      mul;
    logic      hi;
    coef_sel_t coef;
    opnd_sel_t opnd;
    logic      finish;
    stage_t    stage;
    logic      load_out;
  } cmd_t;

  function automatic term_t term_of(input logic [TERM_BITS-1:0] idx);
    term_t t;
    t = '{coef: C_ONE, opnd: X_WORK, last: 1'b1};
    case (idx)
      5'd0:  t = '{coef: C_NEG_ONE,     opnd: X_SAMPLE, last: 1'b1};
      5'd1:  t = '{coef: C_CB0,         opnd: X_WORK,   last: 1'b0};
      5'd2:  t = '{coef: C_NCB0,        opnd: X_CIN1,   last: 1'b0};
      5'd3:  t = '{coef: C_NCA1,        opnd: X_COUT0,  last: 1'b0};
      5'd4:  t = '{coef: C_NCA2,        opnd: X_COUT1,  last: 1'b1};
      5'd5:  t = '{coef: C_GAIN,        opnd: X_COUT0,  last: 1'b0};
      5'd6:  t = '{coef: C_NEG_ONE,     opnd: X_SAMPLE, last: 1'b1};
      5'd7:  t = '{coef: C_KB0,         opnd: X_WORK,   last: 1'b0};
      5'd8:  t = '{coef: C_NKB0,        opnd: X_KIN1,   last: 1'b0};
      5'd9:  t = '{coef: C_NKA1,        opnd: X_KOUT0,  last: 1'b0};
      5'd10: t = '{coef: C_NKA2,        opnd: X_KOUT1,  last: 1'b1};
      5'd11: t = '{coef: C_GAIN,        opnd: X_WORK,   last: 1'b0};
      5'd12: t = '{coef: C_ONE,         opnd: X_KIN0,   last: 1'b1};
      5'd13: t = '{coef: C_AR,          opnd: X_WORK,   last: 1'b1};
      5'd14: t = '{coef: C_HPB0,        opnd: X_WORK,   last: 1'b0};
      5'd15: t = '{coef: C_HPB1,        opnd: X_SIN0,   last: 1'b0};
      5'd16: t = '{coef: C_HPB0,        opnd: X_SIN1,   last: 1'b0};
      5'd17: t = '{coef: C_HPNA1,       opnd: X_VEL0,   last: 1'b0};
      5'd18: t = '{coef: C_HPNA2,       opnd: X_VEL1,   last: 1'b1};
      5'd19: t = '{coef: C_ALPHA,       opnd: X_WORK,   last: 1'b0};
      5'd20: t = '{coef: C_ONE_M_ALPHA, opnd: X_DISP,   last: 1'b1};
      default: t = '{coef: C_ONE, opnd: X_WORK, last: 1'b1};
    endcase
    return t;
  endfunction

endpackage

FILE: hdl/ome_ctrl.sv
// ----------------------------------------------------------------------------
// ome_ctrl
// Sequencer: walks the term program, issues multiply, finish and transfer
// commands to the datapath.
// ----------------------------------------------------------------------------
module ome_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  output logic            m_tvalid,
  input  logic            m_tready,
  output ome_pkg::cmd_t   cmd
);

  ome_pkg::state_t                 state;
  ome_pkg::state_t                 state_next;
  logic [ome_pkg::TERM_BITS-1:0]   term;
  ome_pkg::stage_t                 stage;
  ome_pkg::term_t                  cur;
  logic                            out_free;

  assign cur      = ome_pkg::term_of(term);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      ome_pkg::ST_IDLE:   if (s_tvalid) state_next = ome_pkg::ST_LO;
      ome_pkg::ST_LO:     state_next = ome_pkg::ST_HI;
      ome_pkg::ST_HI:     state_next = cur.last ? ome_pkg::ST_DRAIN : ome_pkg::ST_LO;
      ome_pkg::ST_DRAIN:  state_next = ome_pkg::ST_FINISH;
      ome_pkg::ST_FINISH: begin
        state_next = (stage == ome_pkg::STG_LP) ? ome_pkg::ST_OUT : ome_pkg::ST_LO;
      end
      ome_pkg::ST_OUT:    if (out_free) state_next = ome_pkg::ST_IDLE;
      default:            state_next = ome_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready     = (state == ome_pkg::ST_IDLE);
    cmd.load_in  = (state == ome_pkg::ST_IDLE) && s_tvalid;
    cmd.mul      = (state == ome_pkg::ST_LO) || (state == ome_pkg::ST_HI);
    cmd.hi       = (state == ome_pkg::ST_HI);
    cmd.coef     = cur.coef;
    cmd.opnd     = cur.opnd;
    cmd.finish   = (state == ome_pkg::ST_FINISH);
    cmd.stage    = stage;
    cmd.load_out = (state == ome_pkg::ST_OUT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ome_pkg::ST_IDLE;
      term     <= '0;
      stage    <= ome_pkg::STG_NX;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_in) begin
        term  <= '0;
        stage <= ome_pkg::STG_NX;
      end else if ((state == ome_pkg::ST_HI && !cur.last) ||
                   (state == ome_pkg::ST_FINISH && stage != ome_pkg::STG_LP)) begin
        term <= term + 1'b1;
      end
      if (state == ome_pkg::ST_FINISH && stage != ome_pkg::STG_LP) begin
        stage <= ome_pkg::stage_t'(stage + 1'b1);
      end
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_start: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ome_pkg::ST_LO && term == '0 &&
                                stage == ome_pkg::STG_NX))
    else $error("sequencer did not start at the first term");

  a_end: assert property (@(posedge clk) disable iff (rst)
    (state == ome_pkg::ST_FINISH && stage == ome_pkg::STG_LP) |=>
      (state == ome_pkg::ST_OUT && term == ome_pkg::TERM_BITS'(ome_pkg::LAST_TERM)))
    else $error("program ended off the last term");

  a_result: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ome_pkg::ST_OUT))
    else $error("result raised outside the output step");

endmodule

FILE: hdl/ome_datapath.sv
// ----------------------------------------------------------------------------
// ome_datapath
// Coefficient registers, filter histories and one shared multiply-accumulate
// with rounding, shifting and clipping of each stage result.
// ----------------------------------------------------------------------------
module ome_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  ome_pkg::cmd_t                        cmd,
  input  logic                                 cfg_we,
  input  logic [ome_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [ome_pkg::CFG_BITS-1:0]         cfg_data,
  input  logic [ome_pkg::SAMPLE_BITS-1:0]      s_tdata,
  output logic [ome_pkg::OUT_BITS-1:0]         m_tdata,
  output logic                                 m_tuser
);

  localparam int SB = ome_pkg::SIGNAL_BITS;
  localparam int AB = ome_pkg::ACC_BITS;
  localparam int HB = ome_pkg::HALF_BITS;

  logic signed [31:0] concha_b0, concha_a1, concha_a2;
  logic signed [31:0] canal_b0, canal_a1, canal_a2;
  logic        [23:0] ar_scale;
  logic        [30:0] lp_alpha;

  logic signed [ome_pkg::SAMPLE_BITS-1:0] sample;
  logic signed [SB-1:0] work;
  logic signed [SB-1:0] cin0, cin1, cout0, cout1;
  logic signed [SB-1:0] kin0, kin1, kout0, kout1;
  logic signed [SB-1:0] sin0, sin1, vel0, vel1;
  logic signed [SB-1:0] disp;
  logic                 clip;

  logic signed [ome_pkg::COEF_BITS-1:0] coef;
  logic signed [SB-1:0]                 opnd;
  logic signed [ome_pkg::PART_BITS-1:0] part;
  logic signed [ome_pkg::PROD_BITS-1:0] prod;
  logic                                 prod_valid;
  logic                                 prod_hi;
  logic signed [AB-1:0]                 addend;
  logic signed [AB-1:0]                 acc;
  logic signed [AB-1:0]                 rnd;
  logic signed [AB-1:0]                 shifted;
  logic        [AB-SB:0]                top;
  logic                                 fits;
  logic signed [SB-1:0]                 res;

  always_comb begin
    unique case (cmd.coef)
      ome_pkg::C_NEG_ONE:     coef = -ome_pkg::ONE_Q30;
      ome_pkg::C_ONE:         coef = ome_pkg::ONE_Q30;
      ome_pkg::C_GAIN:        coef = ome_pkg::GAIN_Q30;
      ome_pkg::C_CB0:         coef = ome_pkg::COEF_BITS'(concha_b0);
      ome_pkg::C_NCB0:        coef = -ome_pkg::COEF_BITS'(concha_b0);
      ome_pkg::C_NCA1:        coef = -ome_pkg::COEF_BITS'(concha_a1);
      ome_pkg::C_NCA2:        coef = -ome_pkg::COEF_BITS'(concha_a2);
      ome_pkg::C_KB0:         coef = ome_pkg::COEF_BITS'(canal_b0);
      ome_pkg::C_NKB0:        coef = -ome_pkg::COEF_BITS'(canal_b0);
      ome_pkg::C_NKA1:        coef = -ome_pkg::COEF_BITS'(canal_a1);
      ome_pkg::C_NKA2:        coef = -ome_pkg::COEF_BITS'(canal_a2);
      ome_pkg::C_AR:          coef = {9'b0, ar_scale};
      ome_pkg::C_HPB0:        coef = ome_pkg::HP_B0;
      ome_pkg::C_HPB1:        coef = ome_pkg::HP_B1;
      ome_pkg::C_HPNA1:       coef = ome_pkg::HP_NA1;
      ome_pkg::C_HPNA2:       coef = ome_pkg::HP_NA2;
      ome_pkg::C_ALPHA:       coef = {2'b0, lp_alpha};
      ome_pkg::C_ONE_M_ALPHA: coef = ome_pkg::ONE_Q30 - $signed({2'b0, lp_alpha});
      default:                coef = '0;
    endcase
  end

  always_comb begin
    unique case (cmd.opnd)
      ome_pkg::X_SAMPLE: opnd = SB'(sample) <<< ome_pkg::SAMPLE_SHIFT;
      ome_pkg::X_WORK:   opnd = work;
      ome_pkg::X_CIN1:   opnd = cin1;
      ome_pkg::X_COUT0:  opnd = cout0;
      ome_pkg::X_COUT1:  opnd = cout1;
      ome_pkg::X_KIN0:   opnd = kin0;
      ome_pkg::X_KIN1:   opnd = kin1;
      ome_pkg::X_KOUT0:  opnd = kout0;
      ome_pkg::X_KOUT1:  opnd = kout1;
      ome_pkg::X_SIN0:   opnd = sin0;
      ome_pkg::X_SIN1:   opnd = sin1;
      ome_pkg::X_VEL0:   opnd = vel0;
      ome_pkg::X_VEL1:   opnd = vel1;
      ome_pkg::X_DISP:   opnd = disp;
      default:           opnd = '0;
    endcase
  end

  // low half unsigned, high half signed
  assign part = cmd.hi ? ome_pkg::PART_BITS'($signed(opnd[SB-1:HB]))
                       : $signed({1'b0, opnd[HB-1:0]});

  assign addend = prod_hi ? (AB'(prod) <<< HB) : AB'(prod);

  always_comb begin
    rnd     = acc + ((cmd.stage == ome_pkg::STG_AR) ? ome_pkg::AR_HALF : ome_pkg::Q30_HALF);
    shifted = (cmd.stage == ome_pkg::STG_AR) ? (rnd >>> ome_pkg::AR_SHIFT)
                                             : (rnd >>> ome_pkg::Q30_SHIFT);
    top     = shifted[AB-1:SB-1];
    fits    = (&top) || !(|top);
    if (fits) begin
      res = shifted[SB-1:0];
    end else begin
      res = shifted[AB-1] ? ome_pkg::SIG_MIN : ome_pkg::SIG_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      concha_b0 <= ome_pkg::RST_CONCHA_B0;
      concha_a1 <= ome_pkg::RST_CONCHA_A1;
      concha_a2 <= ome_pkg::RST_CONCHA_A2;
      canal_b0  <= ome_pkg::RST_CANAL_B0;
      canal_a1  <= ome_pkg::RST_CANAL_A1;
      canal_a2  <= ome_pkg::RST_CANAL_A2;
      ar_scale  <= ome_pkg::RST_AR_SCALE;
      lp_alpha  <= ome_pkg::RST_LP_ALPHA;
    end else if (cfg_we) begin
      unique case (ome_pkg::cfg_idx_t'(cfg_index))
        ome_pkg::CFG_CONCHA_B0: concha_b0 <= cfg_data;
        ome_pkg::CFG_CONCHA_A1: concha_a1 <= cfg_data;
        ome_pkg::CFG_CONCHA_A2: concha_a2 <= cfg_data;
        ome_pkg::CFG_CANAL_B0:  canal_b0  <= cfg_data;
        ome_pkg::CFG_CANAL_A1:  canal_a1  <= cfg_data;
        ome_pkg::CFG_CANAL_A2:  canal_a2  <= cfg_data;
        ome_pkg::CFG_AR_SCALE:  ar_scale  <= cfg_data[23:0];
        ome_pkg::CFG_LP_ALPHA:  lp_alpha  <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      acc        <= '0;
      clip       <= 1'b0;
      cin0 <= '0; cin1 <= '0; cout0 <= '0; cout1 <= '0;
      kin0 <= '0; kin1 <= '0; kout0 <= '0; kout1 <= '0;
      sin0 <= '0; sin1 <= '0; vel0  <= '0; vel1  <= '0;
      disp <= '0;
    end else begin
      prod_valid <= cmd.mul;
      if (cmd.finish) begin
        acc <= '0;
      end else if (prod_valid) begin
        acc <= acc + addend;
      end
      if (cmd.load_in) begin
        clip <= 1'b0;
      end else if (cmd.finish && !fits) begin
        clip <= 1'b1;
      end
      if (cmd.finish) begin
        unique case (cmd.stage)
          ome_pkg::STG_CONCHA: begin
            cin1 <= cin0; cin0 <= work; cout1 <= cout0; cout0 <= res;
          end
          ome_pkg::STG_CANAL: begin
            kin1 <= kin0; kin0 <= work; kout1 <= kout0; kout0 <= res;
          end
          ome_pkg::STG_HP: begin
            sin1 <= sin0; sin0 <= work; vel1 <= vel0; vel0 <= res;
          end
          ome_pkg::STG_LP: disp <= res;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    prod    <= ome_pkg::PROD_BITS'(coef) * ome_pkg::PROD_BITS'(part);
    prod_hi <= cmd.hi;
    if (cmd.load_in) begin
      sample <= s_tdata;
    end
    if (cmd.finish) begin
      work <= res;
    end
    if (cmd.load_out) begin
      m_tdata <= disp[ome_pkg::OUT_BITS-1:0];
      m_tuser <= clip;
    end
  end

endmodule

FILE: hdl/outer_middle_ear_filter_chain.sv
// ----------------------------------------------------------------------------
// outer_middle_ear_filter_chain
// Concha and ear-canal band-pass resonances, reflex scaling, stapes high-pass
// and low-pass; one stapes displacement per pressure sample.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tdata: pressure_sample[23:0]
//  m_*       out  m_tvalid/m_tready  tdata: stapes_displacement[47:0]; tuser: saturated
//  cfg_*     in   cfg_we             cfg_index (register 0..7), cfg_data[31:0]
//
//  Each sample takes 21 products through one 33x25 multiplier, each taken
//  as two halves of the operand, plus a drain and a finish step per stage,
//  plus input and output steps. Input ready only when idle.
//  A result waits in the output register; a stalled m_tready holds the next
//  sample in its output step. Synchronous reset restores coefficients and
//  clears all filter history.
// ----------------------------------------------------------------------------
module outer_middle_ear_filter_chain (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [ome_pkg::SAMPLE_BITS-1:0]     s_tdata,   // [23:0] pressure_sample
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [ome_pkg::OUT_BITS-1:0]        m_tdata,   // [47:0] stapes_displacement
  output logic                                m_tuser,   // [0] saturated
  input  logic                                cfg_we,
  input  logic [ome_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [ome_pkg::CFG_BITS-1:0]        cfg_data
);

  ome_pkg::cmd_t cmd;

  ome_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  ome_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

FILE: tb/ome_stapes_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ome_stapes_checker
// Watches the sample, result and register ports of the outer/middle ear
// filter chain. It keeps its own copy of the coefficients and filter history
// and works out, for each accepted pressure sample, the stapes displacement
// and clip flag. It then compares each result transfer against the oldest
// prediction and counts mismatches.
// ----------------------------------------------------------------------------
module ome_stapes_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [ome_pkg::SAMPLE_BITS-1:0]  s_tdata,   // [23:0] pressure_sample
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [ome_pkg::OUT_BITS-1:0]     m_tdata,   // [47:0] stapes_displacement
  input  logic                             m_tuser,   // [0] saturated
  input  logic                             cfg_we,
  input  logic [ome_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [ome_pkg::CFG_BITS-1:0]     cfg_data,
  output int                               mismatches,
  output int                               in_flight,
  output int                               checked,
  output int                               clipped
);
  import ome_pkg::*;

  typedef logic signed [SIGNAL_BITS-1:0] sig_t;
  typedef logic signed [127:0] wide_t;
  typedef struct packed {
    logic [OUT_BITS-1:0] disp;
    logic                sat;
  } stapes_t;

  localparam int     FRAC_SH = 30;
  localparam int     AR_SH   = 8;
  localparam longint UNITY   = 64'sd1073741824;
  localparam longint EAR_GAIN = 64'sd1909412977;
  localparam longint HPF_B0  = 64'sd932450869;
  localparam longint HPF_B1  = -64'sd1864901738;
  localparam longint HPF_A1  = -64'sd1846228435;
  localparam longint HPF_A2  = 64'sd809833218;
  localparam wide_t  SIG_TOP    = (wide_t'(1) <<< (SIGNAL_BITS - 1)) - 1;
  localparam wide_t  SIG_BOTTOM = -(wide_t'(1) <<< (SIGNAL_BITS - 1));

  longint concha_b0, concha_a1, concha_a2;
  longint canal_b0, canal_a1, canal_a2;
  longint ar_gain, lp_alpha;

  sig_t concha_x [2];
  sig_t concha_y [2];
  sig_t canal_x [2];
  sig_t canal_y [2];
  sig_t stapes_x [2];
  sig_t stapes_v [2];
  sig_t stapes_d;

  logic    clip_seen;
  stapes_t stapes_q [$];
  int      n_bad, n_checked, n_clipped;

  function automatic wide_t prod(input longint c, input longint x);
    wide_t a, b;
    a = c;
    b = x;
    return a * b;
  endfunction

  // round half up, arithmetic shift, clip to the signal width
  function automatic sig_t scale_clip(input wide_t acc, input int sh);
    wide_t r;
    r = (acc + (wide_t'(1) <<< (sh - 1))) >>> sh;
    if (r > SIG_TOP) begin
      clip_seen = 1'b1;
      return SIG_TOP[SIGNAL_BITS-1:0];
    end
    if (r < SIG_BOTTOM) begin
      clip_seen = 1'b1;
      return SIG_BOTTOM[SIGNAL_BITS-1:0];
    end
    return r[SIGNAL_BITS-1:0];
  endfunction

  task automatic run_chain(input logic [SAMPLE_BITS-1:0] raw, output stapes_t res);
    longint p;
    sig_t   nx, concha, ec_in, ec_res, ec_out, ar, vel, disp;
    p = longint'(signed'(raw)) * 65536;
    clip_seen = 1'b0;

    nx = scale_clip(prod(-UNITY, p), FRAC_SH);
    concha = scale_clip(prod(concha_b0, nx) + prod(-concha_b0, concha_x[1])
                        + prod(-concha_a1, concha_y[0]) + prod(-concha_a2, concha_y[1]),
                        FRAC_SH);
    concha_x[1] = concha_x[0];
    concha_x[0] = nx;
    concha_y[1] = concha_y[0];
    concha_y[0] = concha;

    // concha resonance added to the negated sample
    ec_in = scale_clip(prod(EAR_GAIN, concha) + prod(-UNITY, p), FRAC_SH);
    ec_res = scale_clip(prod(canal_b0, ec_in) + prod(-canal_b0, canal_x[1])
                        + prod(-canal_a1, canal_y[0]) + prod(-canal_a2, canal_y[1]),
                        FRAC_SH);
    canal_x[1] = canal_x[0];
    canal_x[0] = ec_in;
    canal_y[1] = canal_y[0];
    canal_y[0] = ec_res;
    ec_out = scale_clip(prod(EAR_GAIN, ec_res) + prod(UNITY, ec_in), FRAC_SH);

    ar = scale_clip(prod(ar_gain, ec_out), AR_SH);

    vel = scale_clip(prod(HPF_B0, ar) + prod(HPF_B1, stapes_x[0]) + prod(HPF_B0, stapes_x[1])
                     + prod(-HPF_A1, stapes_v[0]) + prod(-HPF_A2, stapes_v[1]), FRAC_SH);
    stapes_x[1] = stapes_x[0];
    stapes_x[0] = ar;
    stapes_v[1] = stapes_v[0];
    stapes_v[0] = vel;

    // alpha above one makes the feedback term negative; used as given
    disp = scale_clip(prod(lp_alpha, vel) + prod(UNITY - lp_alpha, stapes_d), FRAC_SH);
    stapes_d = disp;

    res.disp = disp;
    res.sat  = clip_seen;
  endtask

  always @(posedge clk) begin
    stapes_t want;
    if (rst) begin
      concha_b0 = RST_CONCHA_B0;
      concha_a1 = RST_CONCHA_A1;
      concha_a2 = RST_CONCHA_A2;
      canal_b0  = RST_CANAL_B0;
      canal_a1  = RST_CANAL_A1;
      canal_a2  = RST_CANAL_A2;
      ar_gain   = RST_AR_SCALE;
      lp_alpha  = RST_LP_ALPHA;
      for (int i = 0; i < 2; i++) begin
        concha_x[i] = '0;
        concha_y[i] = '0;
        canal_x[i]  = '0;
        canal_y[i]  = '0;
        stapes_x[i] = '0;
        stapes_v[i] = '0;
      end
      stapes_d = '0;
      stapes_q.delete();
      n_bad     = 0;
      n_checked = 0;
      n_clipped = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_CONCHA_B0: concha_b0 = signed'(cfg_data);
          CFG_CONCHA_A1: concha_a1 = signed'(cfg_data);
          CFG_CONCHA_A2: concha_a2 = signed'(cfg_data);
          CFG_CANAL_B0:  canal_b0  = signed'(cfg_data);
          CFG_CANAL_A1:  canal_a1  = signed'(cfg_data);
          CFG_CANAL_A2:  canal_a2  = signed'(cfg_data);
          CFG_AR_SCALE:  ar_gain   = cfg_data[23:0];
          CFG_LP_ALPHA:  lp_alpha  = cfg_data[30:0];
          default: ;
        endcase
      end

      if (m_tvalid && m_tready) begin
        n_checked++;
        if (m_tuser) n_clipped++;
        if (stapes_q.size() == 0) begin
          $display("%0t: result transfer with nothing predicted, got %h sat %b",
                   $time, m_tdata, m_tuser);
          n_bad++;
        end else begin
          want = stapes_q.pop_front();
          if (m_tdata !== want.disp) begin
            $display("%0t: displacement mismatch, expected %h got %h",
                     $time, want.disp, m_tdata);
            n_bad++;
          end
          if (m_tuser !== want.sat) begin
            $display("%0t: saturated flag mismatch, expected %b got %b",
                     $time, want.sat, m_tuser);
            n_bad++;
          end
        end
      end

      if (s_tvalid && s_tready) begin
        run_chain(s_tdata, want);
        stapes_q.push_back(want);
      end
    end
    mismatches <= n_bad;
    checked    <= n_checked;
    clipped    <= n_clipped;
    in_flight  <= stapes_q.size();
  end

endmodule

FILE: tb/outer_middle_ear_filter_chain_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// outer_middle_ear_filter_chain_test
// Streams pressure samples into the filter chain under a series of register
// settings (reset values, all-extreme, unity alpha, near-nominal and random) with bursty
// input and a stalling result side. A checker beside the block predicts every
// stapes displacement and clip flag; this module drives and gives the verdict.
// ----------------------------------------------------------------------------
module outer_middle_ear_filter_chain_test;
  import ome_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_SAMPLES = 114;
  localparam int OPENING_LEN   = 12;
  localparam int DRAIN_CYCLES  = 120;

  typedef enum {SET_MAX, SET_MIN, SET_UNITY_ALPHA, SET_NEAR, SET_MIXED} setting_t;
  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_BLOCKED} rx_pattern_t;

  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    s_tvalid  = 1'b0;
  logic                    s_tready;
  logic [SAMPLE_BITS-1:0]  s_tdata   = '0;
  logic                    m_tvalid;
  logic                    m_tready  = 1'b0;
  logic [OUT_BITS-1:0]     m_tdata;
  logic                    m_tuser;
  logic                    cfg_we    = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_BITS-1:0]     cfg_data  = '0;

  int mismatches, in_flight, checked, clipped;
  int cycles     = 0;
  int sent       = 0;
  int settings   = 0;
  int burst_left = 0;
  int rx_tick    = 0;
  rx_pattern_t rx_pattern = RX_OPEN;
  logic [SAMPLE_BITS-1:0] last_sample = '0;

  outer_middle_ear_filter_chain u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ome_stapes_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .in_flight  (in_flight),
    .checked    (checked),
    .clipped    (clipped)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, in_flight);
      $display("tb: failure");
      $finish;
    end
  end

  // result side: m_tready follows a stall pattern that rx_tick redraws at random
  always @(negedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick % 256 == 0) rx_pattern <= rx_pattern_t'($urandom_range(0, 3));
    case (rx_pattern)
      RX_OPEN:   m_tready <= 1'b1;
      RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: m_tready <= (rx_tick % 4 == 0);
      default:   m_tready <= ((rx_tick / 16) % 4 == 0);
    endcase
  end

  function automatic logic [SAMPLE_BITS-1:0] opening_sample(input int k);
    case (k)
      0:       return 24'h000000;
      1, 3:    return 24'h7FFFFF;
      2, 4:    return 24'h800000;
      5:       return 24'h000001;
      6:       return 24'hFFFFFF;
      7:       return 24'h555555;
      8:       return 24'hAAAAAA;
      9, 10:   return 24'h7FFFFF;
      default: return 24'h000000;
    endcase
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample(input logic [SAMPLE_BITS-1:0] prev);
    case ($urandom_range(0, 7))
      0:       return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      1:       return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      2:       return prev;
      3, 4:    return SAMPLE_BITS'(int'($urandom_range(0, 2047)) - 1024);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_BITS-1:0] pick_value(input cfg_idx_t idx, input setting_t kind);
    logic [CFG_BITS-1:0] noise, dflt, top, bottom, near, unity;
    int roll;
    noise = $urandom;
    roll  = $urandom_range(0, 9);
    case (idx)
      CFG_CONCHA_B0: dflt = RST_CONCHA_B0;
      CFG_CONCHA_A1: dflt = RST_CONCHA_A1;
      CFG_CONCHA_A2: dflt = RST_CONCHA_A2;
      CFG_CANAL_B0:  dflt = RST_CANAL_B0;
      CFG_CANAL_A1:  dflt = RST_CANAL_A1;
      CFG_CANAL_A2:  dflt = RST_CANAL_A2;
      CFG_AR_SCALE:  dflt = {noise[31:24], RST_AR_SCALE};
      default:       dflt = {noise[31], RST_LP_ALPHA};
    endcase
    unity = dflt;
    // unused upper bits of the narrow registers carry noise
    if (idx == CFG_AR_SCALE) begin
      top    = {noise[31:24], 24'hFFFFFF};
      bottom = {noise[31:24], 24'h000000};
      near   = {noise[31:24], 4'h0, noise[19:0]};
    end else if (idx == CFG_LP_ALPHA) begin
      top    = {noise[31], 31'h7FFFFFFF};
      bottom = {noise[31], 31'h00000000};
      near   = {noise[31], 31'($urandom_range(0, 1 << 30))};
      unity  = {noise[31], 31'(1 << 30)};
    end else begin
      top    = 32'h7FFFFFFF;
      bottom = 32'h80000000;
      near   = dflt + 32'($urandom_range(0, 65535)) - 32'd32768;
    end
    case (kind)
      SET_MAX:         return top;
      SET_MIN:         return bottom;
      SET_UNITY_ALPHA: return unity;
      SET_NEAR:        return near;
      default: begin
        if (roll <= 5) return near;
        if (roll <= 7) return noise;
        if (roll == 8) return top;
        return bottom;
      end
    endcase
  endfunction

  task automatic push_sample(input logic [SAMPLE_BITS-1:0] smp);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    last_sample = smp;
    sent++;
  endtask

  task automatic stream_sample(input logic [SAMPLE_BITS-1:0] smp);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 90);
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    push_sample(smp);
  endtask

  // stop sending and wait until every predicted result has been transferred
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (in_flight != 0) @(negedge clk);
  endtask

  task automatic apply_setting(input setting_t kind);
    cfg_idx_t idx;
    for (int i = CFG_CONCHA_B0; i <= CFG_LP_ALPHA; i++) begin
      idx = cfg_idx_t'(i);
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= pick_value(idx, kind);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  initial begin
    setting_t kind;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    settings = 1;

    for (int k = 0; k < OPENING_LEN; k++) push_sample(opening_sample(k));
    settle();
    // every coefficient at full scale: clipping and alpha above one
    apply_setting(SET_MAX);
    for (int k = 0; k < OPENING_LEN; k++) push_sample(opening_sample(k));
    settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) kind = SET_MIN;
      else if (p == 1) kind = SET_UNITY_ALPHA;
      else if (p % 2 == 0) kind = SET_NEAR;
      else kind = SET_MIXED;
      apply_setting(kind);
      for (int k = 0; k < PHASE_SAMPLES; k++) begin
        if (p == 2 && k == PHASE_SAMPLES / 2) settle();
        stream_sample(pick_sample(last_sample));
      end
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("summary: %0d pressure samples under %0d register settings", sent, settings);
    $display("summary: %0d displacements compared, %0d flagged as clipped", checked, clipped);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/ome_pkg.sv
hdl/ome_ctrl.sv
hdl/ome_datapath.sv
hdl/outer_middle_ear_filter_chain.sv
tb/ome_stapes_checker.sv
tb/outer_middle_ear_filter_chain_test.sv
